>>> src/bbx_pkg.sv
// Shared types and constants for the cubic Bezier bounding box block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package bbx_pkg;

    // coordinate and curve parameter formats
    localparam int CW = 16;             // coordinate width
    localparam int TF = 16;             // fraction bits of t
    localparam int TW = TF + 1;         // t in [0, 1] needs one integer bit
    localparam logic [TW-1:0] TONE = TW'(1) << TF;

    // pipeline depths
    localparam int SQ_N     = 31;       // one root bit per square-root stage
    localparam int DIV_N    = TF + 1;   // one quotient bit per divide stage
    localparam int AX_LAT   = 6 + SQ_N + DIV_N;
    localparam int EVAL_LAT = 6;
    localparam int TOT_LAT  = AX_LAT + EVAL_LAT + 1;

    typedef logic signed [CW-1:0] t_coord;

    typedef struct packed {
        t_coord start_x;
        t_coord start_y;
        t_coord ctrl1_x;
        t_coord ctrl1_y;
        t_coord ctrl2_x;
        t_coord ctrl2_y;
        t_coord end_x;
        t_coord end_y;
    } t_curve;

    typedef struct packed {
        t_coord box_min_x;
        t_coord box_max_x;
        t_coord box_min_y;
        t_coord box_max_y;
    } t_box;

    // control points of one axis
    typedef struct packed {
        t_coord p0;
        t_coord p1;
        t_coord p2;
        t_coord p3;
    } t_pts;

    // roots found on one axis, with end point extremes
    typedef struct packed {
        t_pts          pts;
        t_coord        lo;
        t_coord        hi;
        logic [TW-1:0] t1;
        logic          ok1;
        logic [TW-1:0] t2;
        logic          ok2;
    } t_roots;

    // curve value at one root, rounded both ways
    typedef struct packed {
        t_coord fl;
        t_coord cl;
        logic   ok;
    } t_hit;

endpackage

>>> src/bbx_axis.sv
// Per-axis root finder: coefficients, discriminant, pipelined square root
// and two pipelined restoring dividers. Depends on bbx_pkg.
`timescale 1ns / 1ps

module bbx_axis import bbx_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_vld,
    input  t_pts   i_pts,
    output logic   o_vld,
    output t_roots o_roots
);

    typedef struct packed {
        logic [33:0] rem;
        logic [30:0] root;
        logic [61:0] n;
    } t_sq;

    typedef struct packed {
        t_pts               pts;
        t_coord             lo;
        t_coord             hi;
        logic signed [39:0] nb;
        logic signed [21:0] den;
        logic [4:0]         sh;
        logic               ok1;
        logic               ok2;
    } t_ctx;

    typedef struct packed {
        logic [39:0] rem;
        logic [20:0] dm;
        logic [TW-1:0] q;
        logic        ok;
    } t_dv;

    typedef struct packed {
        t_pts   pts;
        t_coord lo;
        t_coord hi;
    } t_front;

    // one bit of the square root
    function automatic t_sq sq_step(input t_sq x, input int j);
        logic [35:0] cand;
        logic [35:0] trial;
        t_sq         y;
        begin
            y     = x;
            cand  = {x.rem, x.n[2*j+1 -: 2]};
            trial = {3'b000, x.root, 2'b01};
            if (cand >= trial) begin
                y.rem  = 34'(cand - trial);
                y.root = {x.root[29:0], 1'b1};
            end else begin
                y.rem  = cand[33:0];
                y.root = {x.root[29:0], 1'b0};
            end
            return y;
        end
    endfunction

    // one quotient bit
    function automatic t_dv dv_step(input t_dv x, input int i);
        logic [39:0] sub;
        t_dv         y;
        begin
            y   = x;
            sub = 40'(x.dm) << i;
            if (x.rem >= sub) begin
                y.rem  = x.rem - sub;
                y.q[i] = 1'b1;
            end
            return y;
        end
    endfunction

    // magnitudes, sign test and range check before dividing
    function automatic t_dv dv_init(input logic signed [40:0] num,
                                    input logic signed [21:0] den,
                                    input logic okb);
        logic [40:0] mn;
        logic [21:0] md;
        t_dv         y;
        begin
            mn    = num[40] ? 41'(-num) : 41'(num);
            md    = den[21] ? 22'(-den) : 22'(den);
            y.rem = mn[39:0];
            y.dm  = md[20:0];
            y.q   = '0;
            y.ok  = okb && !((num != '0) && (num[40] != den[21]))
                    && (mn < 41'({md[20:0], 17'b0}));
            return y;
        end
    endfunction

    // stage 0: power-basis coefficients of the derivative
    logic               r0_vld;
    t_pts               r0_pts;
    logic signed [20:0] r0_a, r0_b;
    logic signed [18:0] r0_c;
    t_coord             r0_lo, r0_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else begin
            r0_vld <= i_vld;
        end
        r0_pts <= i_pts;
        r0_a   <= 21'(3 * i_pts.p3 - 9 * i_pts.p2 + 9 * i_pts.p1 - 3 * i_pts.p0);
        r0_b   <= 21'(6 * i_pts.p2 - 12 * i_pts.p1 + 6 * i_pts.p0);
        r0_c   <= 19'(3 * i_pts.p1 - 3 * i_pts.p0);
        r0_lo  <= (i_pts.p0 < i_pts.p3) ? i_pts.p0 : i_pts.p3;
        r0_hi  <= (i_pts.p0 > i_pts.p3) ? i_pts.p0 : i_pts.p3;
    end

    // stage 1: discriminant
    logic signed [41:0] c_bb;
    logic signed [39:0] c_ac;
    logic               r1_vld;
    t_pts               r1_pts;
    logic signed [20:0] r1_a, r1_b;
    logic signed [18:0] r1_c;
    t_coord             r1_lo, r1_hi;
    logic signed [42:0] r1_d;

    assign c_bb = r0_b * r0_b;
    assign c_ac = r0_a * r0_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
        end else begin
            r1_vld <= r0_vld;
        end
        r1_pts <= r0_pts;
        r1_a   <= r0_a;
        r1_b   <= r0_b;
        r1_c   <= r0_c;
        r1_lo  <= r0_lo;
        r1_hi  <= r0_hi;
        r1_d   <= 43'(c_bb) - (43'(c_ac) <<< 2);
    end

    // stage 2: pick root scale, set up numerator base and divisor
    logic        c_lin, c_neg;
    logic [41:0] c_du;
    logic [4:0]  c_s;
    t_ctx        c_ctx;
    t_sq         c_sq;

    logic        r_vld [0:SQ_N];
    t_ctx        r_ctx [0:SQ_N];
    t_sq         r_sq  [0:SQ_N];

    always_comb begin
        c_lin = (r1_a == '0);
        c_neg = r1_d[42];
        c_du  = r1_d[41:0];
        c_s   = '0;
        for (int k = 0; k <= TF; k++) begin
            if ((c_du >> (62 - 2 * k)) == '0) begin
                c_s = 5'(k);
            end
        end
        c_ctx.pts = r1_pts;
        c_ctx.lo  = r1_lo;
        c_ctx.hi  = r1_hi;
        c_ctx.nb  = c_lin ? -(40'(r1_c) <<< TF) : -(40'(r1_b) <<< TF);
        c_ctx.den = c_lin ? 22'(r1_b) : (22'(r1_a) <<< 1);
        c_ctx.sh  = 5'(TF) - c_s;
        c_ctx.ok1 = c_lin ? (r1_b != '0) : !c_neg;
        c_ctx.ok2 = !c_lin && !c_neg;
        c_sq.rem  = '0;
        c_sq.root = '0;
        c_sq.n    = (c_lin || c_neg) ? '0 : (62'(c_du) << {c_s, 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else begin
            r_vld[0] <= r1_vld;
        end
        r_ctx[0] <= c_ctx;
        r_sq[0]  <= c_sq;
    end

    // square root stages, most significant bit first
    genvar g;
    generate
        for (g = 0; g < SQ_N; g++) begin : g_sq
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[g+1] <= 1'b0;
                end else begin
                    r_vld[g+1] <= r_vld[g];
                end
                r_ctx[g+1] <= r_ctx[g];
                r_sq[g+1]  <= sq_step(r_sq[g], SQ_N - 1 - g);
            end
        end
    endgenerate

    // numerators of both roots
    logic [47:0]        c_rs;
    logic               r3_vld;
    t_front             r3_fr;
    logic signed [40:0] r3_n1, r3_n2;
    logic signed [21:0] r3_den;
    logic               r3_ok1, r3_ok2;

    assign c_rs = 48'(r_sq[SQ_N].root) << r_ctx[SQ_N].sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_vld <= 1'b0;
        end else begin
            r3_vld <= r_vld[SQ_N];
        end
        r3_fr.pts <= r_ctx[SQ_N].pts;
        r3_fr.lo  <= r_ctx[SQ_N].lo;
        r3_fr.hi  <= r_ctx[SQ_N].hi;
        r3_n1     <= 41'(r_ctx[SQ_N].nb) + $signed({1'b0, c_rs[39:0]});
        r3_n2     <= 41'(r_ctx[SQ_N].nb) - $signed({1'b0, c_rs[39:0]});
        r3_den    <= r_ctx[SQ_N].den;
        r3_ok1    <= r_ctx[SQ_N].ok1;
        r3_ok2    <= r_ctx[SQ_N].ok2;
    end

    // divider lanes, one per root
    logic   r_dvld [0:DIV_N];
    t_front r_fr   [0:DIV_N];
    t_dv    r_d1   [0:DIV_N];
    t_dv    r_d2   [0:DIV_N];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvld[0] <= 1'b0;
        end else begin
            r_dvld[0] <= r3_vld;
        end
        r_fr[0] <= r3_fr;
        r_d1[0] <= dv_init(r3_n1, r3_den, r3_ok1);
        r_d2[0] <= dv_init(r3_n2, r3_den, r3_ok2);
    end

    generate
        for (g = 0; g < DIV_N; g++) begin : g_dv
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_dvld[g+1] <= 1'b0;
                end else begin
                    r_dvld[g+1] <= r_dvld[g];
                end
                r_fr[g+1] <= r_fr[g];
                r_d1[g+1] <= dv_step(r_d1[g], DIV_N - 1 - g);
                r_d2[g+1] <= dv_step(r_d2[g], DIV_N - 1 - g);
            end
        end
    endgenerate

    // keep roots with t <= 1
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= r_dvld[DIV_N];
        end
        o_roots.pts <= r_fr[DIV_N].pts;
        o_roots.lo  <= r_fr[DIV_N].lo;
        o_roots.hi  <= r_fr[DIV_N].hi;
        o_roots.t1  <= r_d1[DIV_N].q;
        o_roots.ok1 <= r_d1[DIV_N].ok && (r_d1[DIV_N].q <= TONE);
        o_roots.t2  <= r_d2[DIV_N].q;
        o_roots.ok2 <= r_d2[DIV_N].ok && (r_d2[DIV_N].q <= TONE);
    end

endmodule

>>> src/bbx_eval.sv
// Evaluation lane: de Casteljau on one axis at one root, floor and ceil.
// Depends on bbx_pkg.
`timescale 1ns / 1ps

module bbx_eval import bbx_pkg::*; (
    input  logic          i_clk,
    input  t_pts          i_pts,
    input  logic [TW-1:0] i_t,
    input  logic          i_ok,
    output t_hit          o_hit
);

    // (q - p) * t, exact
    function automatic logic signed [50:0] mul_t(input logic signed [31:0] p,
                                                 input logic signed [31:0] q,
                                                 input logic [TW-1:0] t);
        logic signed [32:0] d;
        begin
            d = 33'(q) - 33'(p);
            return d * $signed({1'b0, t});
        end
    endfunction

    // p + floor(prod / 2^TF)
    function automatic logic signed [31:0] lerp_add(input logic signed [31:0] p,
                                                    input logic signed [50:0] prod);
        logic [34:0] s;
        begin
            s = 35'(p) + prod[50:TF];
            return s[31:0];
        end
    endfunction

    logic signed [31:0] c_s [0:3];

    assign c_s[0] = {i_pts.p0, 16'b0};
    assign c_s[1] = {i_pts.p1, 16'b0};
    assign c_s[2] = {i_pts.p2, 16'b0};
    assign c_s[3] = {i_pts.p3, 16'b0};

    // level 1 products
    logic signed [50:0] r1_prod [0:2];
    logic signed [31:0] r1_s    [0:2];
    logic [TW-1:0]      r1_t;
    logic               r1_ok;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r1_prod[j] <= mul_t(c_s[j], c_s[j+1], i_t);
            r1_s[j]    <= c_s[j];
        end
        r1_t  <= i_t;
        r1_ok <= i_ok;
    end

    // level 1 points
    logic signed [31:0] r2_u [0:2];
    logic [TW-1:0]      r2_t;
    logic               r2_ok;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 3; j++) begin
            r2_u[j] <= lerp_add(r1_s[j], r1_prod[j]);
        end
        r2_t  <= r1_t;
        r2_ok <= r1_ok;
    end

    // level 2 products
    logic signed [50:0] r3_prod [0:1];
    logic signed [31:0] r3_u    [0:1];
    logic [TW-1:0]      r3_t;
    logic               r3_ok;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 2; j++) begin
            r3_prod[j] <= mul_t(r2_u[j], r2_u[j+1], r2_t);
            r3_u[j]    <= r2_u[j];
        end
        r3_t  <= r2_t;
        r3_ok <= r2_ok;
    end

    // level 2 points
    logic signed [31:0] r4_w [0:1];
    logic [TW-1:0]      r4_t;
    logic               r4_ok;

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < 2; j++) begin
            r4_w[j] <= lerp_add(r3_u[j], r3_prod[j]);
        end
        r4_t  <= r3_t;
        r4_ok <= r3_ok;
    end

    // last product
    logic signed [50:0] r5_prod;
    logic signed [31:0] r5_w0;
    logic               r5_ok;

    always_ff @(posedge i_clk) begin
        r5_prod <= mul_t(r4_w[0], r4_w[1], r4_t);
        r5_w0   <= r4_w[0];
        r5_ok   <= r4_ok;
    end

    // curve point, rounded down and up
    logic signed [31:0] c_v;
    logic signed [32:0] c_vc;

    assign c_v  = lerp_add(r5_w0, r5_prod);
    assign c_vc = 33'(c_v) + 33'((1 << TF) - 1);

    always_ff @(posedge i_clk) begin
        o_hit.fl <= c_v[31:TF];
        o_hit.cl <= c_vc[31:TF];
        o_hit.ok <= r5_ok;
    end

endmodule

>>> src/cubic_bezier_bounding_box_top.sv
// o_box is valid with o_done.
// Throughput: one curve per cycle; o_busy is always low and results cannot be held off.
// The depth is set by the 31-stage square root and the 17-stage dividers of each axis.
// Reset (synchronous, active low) clears the valid pipeline; nothing carries between curves.
// Top level: two axis root finders, four evaluation lanes, merge stage. Depends on bbx_pkg.
`timescale 1ns / 1ps

module cubic_bezier_bounding_box_top import bbx_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  t_curve i_curve,
    output logic   o_busy,
    output logic   o_done,
    output t_box   o_box
);

    typedef struct packed {
        t_coord xlo;
        t_coord xhi;
        t_coord ylo;
        t_coord yhi;
    } t_ep;

    t_pts   c_px, c_py;
    logic   c_xvld, c_yvld;
    t_roots c_rx, c_ry;
    t_hit   c_hx1, c_hx2, c_hy1, c_hy2;

    assign o_busy = 1'b0;

    assign c_px = '{p0: i_curve.start_x, p1: i_curve.ctrl1_x,
                    p2: i_curve.ctrl2_x, p3: i_curve.end_x};
    assign c_py = '{p0: i_curve.start_y, p1: i_curve.ctrl1_y,
                    p2: i_curve.ctrl2_y, p3: i_curve.end_y};

    // root finders
    bbx_axis u_ax_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_start && !o_busy),
        .i_pts   (c_px),
        .o_vld   (c_xvld),
        .o_roots (c_rx)
    );

    bbx_axis u_ax_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_start && !o_busy),
        .i_pts   (c_py),
        .o_vld   (c_yvld),
        .o_roots (c_ry)
    );

    // evaluation lanes
    bbx_eval u_ev_x1 (.i_clk(i_clk), .i_pts(c_rx.pts), .i_t(c_rx.t1), .i_ok(c_rx.ok1),
                      .o_hit(c_hx1));
    bbx_eval u_ev_x2 (.i_clk(i_clk), .i_pts(c_rx.pts), .i_t(c_rx.t2), .i_ok(c_rx.ok2),
                      .o_hit(c_hx2));
    bbx_eval u_ev_y1 (.i_clk(i_clk), .i_pts(c_ry.pts), .i_t(c_ry.t1), .i_ok(c_ry.ok1),
                      .o_hit(c_hy1));
    bbx_eval u_ev_y2 (.i_clk(i_clk), .i_pts(c_ry.pts), .i_t(c_ry.t2), .i_ok(c_ry.ok2),
                      .o_hit(c_hy2));

    // end point extremes wait for the lanes
    logic r_ev [0:EVAL_LAT-1];
    t_ep  r_ep [0:EVAL_LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < EVAL_LAT; k++) begin
                r_ev[k] <= 1'b0;
            end
        end else begin
            r_ev[0] <= c_xvld && c_yvld;
            for (int k = 1; k < EVAL_LAT; k++) begin
                r_ev[k] <= r_ev[k-1];
            end
        end
        r_ep[0] <= '{xlo: c_rx.lo, xhi: c_rx.hi, ylo: c_ry.lo, yhi: c_ry.hi};
        for (int k = 1; k < EVAL_LAT; k++) begin
            r_ep[k] <= r_ep[k-1];
        end
    end

    // merge lane results with the end points
    function automatic t_coord lo3(input t_coord e, input t_hit a, input t_hit b);
        t_coord m;
        begin
            m = e;
            if (a.ok && (a.fl < m)) m = a.fl;
            if (b.ok && (b.fl < m)) m = b.fl;
            return m;
        end
    endfunction

    function automatic t_coord hi3(input t_coord e, input t_hit a, input t_hit b);
        t_coord m;
        begin
            m = e;
            if (a.ok && (a.cl > m)) m = a.cl;
            if (b.ok && (b.cl > m)) m = b.cl;
            return m;
        end
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= r_ev[EVAL_LAT-1];
        end
        o_box.box_min_x <= lo3(r_ep[EVAL_LAT-1].xlo, c_hx1, c_hx2);
        o_box.box_max_x <= hi3(r_ep[EVAL_LAT-1].xhi, c_hx1, c_hx2);
        o_box.box_min_y <= lo3(r_ep[EVAL_LAT-1].ylo, c_hy1, c_hy2);
        o_box.box_max_y <= hi3(r_ep[EVAL_LAT-1].yhi, c_hy1, c_hy2);
    end

endmodule

>>> src/bbx_check.sv
// Port-level checker for the bounding box top level, attached by bind.
// Depends on bbx_pkg and cubic_bezier_bounding_box_top.
`timescale 1ns / 1ps

module bbx_check import bbx_pkg::*; (
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_start,
    input t_curve i_curve,
    input logic   o_busy,
    input logic   o_done,
    input t_box   o_box
);

    // the pipeline never refuses a curve
    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n) !o_busy)
        else $error("busy raised");

    // every accepted curve comes out after the fixed latency
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##TOT_LAT o_done)
        else $error("result missing after start transfer");

    // box is never inverted
    a_box_x: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_box.box_min_x <= o_box.box_max_x))
        else $error("x box inverted");

    a_box_y: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_box.box_min_y <= o_box.box_max_y))
        else $error("y box inverted");

    // reset flushes pending results
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !o_done)
        else $error("result after reset");

endmodule

bind cubic_bezier_bounding_box_top bbx_check u_check (.*);

>>> tb/cubic_bezier_bounding_box_checker.sv
// Checker for the cubic Bezier bounding box block: predicts each box and compares it.
// Watches the start and done channels at the clock edge. Depends on bbx_pkg.
`timescale 1ns / 1ps

module cubic_bezier_bounding_box_checker import bbx_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_start,
    input  logic   i_busy,
    input  t_curve i_curve,
    input  logic   i_done,
    input  t_box   i_box,
    output int     o_fail_cnt,
    output int     o_pending,
    output int     o_box_cnt
);

    typedef longint t_quad [4];

    localparam longint unsigned T_UNIT = 64'd1 << TF;
    localparam longint unsigned T_MASK = T_UNIT - 1;

    t_box box_queue [$];

    function automatic longint unsigned abs_val(longint x);
        return x < 0 ? 64'd0 - longint'(x) : x;
    endfunction

    // bitwise integer square root
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv >>= 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n -= res + bitv;
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // floor(x * t / 2^TF), exact
    function automatic longint scale_by_t(longint x, longint unsigned t);
        longint unsigned m, hi, lo, p;
        m = abs_val(x);
        hi = m >> TF;
        lo = m & T_MASK;
        p = lo * t;
        if (x >= 0) return longint'(hi * t + (p >> TF));
        return -longint'(hi * t + ((p + T_MASK) >> TF));
    endfunction

    function automatic longint round_down(longint v);
        if (v >= 0) return longint'(longint'(v) >>> TF);
        return -longint'((abs_val(v) + T_MASK) >> TF);
    endfunction

    function automatic longint blend(longint p, longint q, longint unsigned t);
        return p + scale_by_t(q - p, t);
    endfunction

    // de Casteljau at t, scale 2^TF
    function automatic longint curve_at(t_quad p, longint unsigned t);
        longint s0, s1, s2, s3, u0, u1, u2, w0, w1;
        s0 = p[0] * longint'(T_UNIT);
        s1 = p[1] * longint'(T_UNIT);
        s2 = p[2] * longint'(T_UNIT);
        s3 = p[3] * longint'(T_UNIT);
        u0 = blend(s0, s1, t);
        u1 = blend(s1, s2, t);
        u2 = blend(s2, s3, t);
        w0 = blend(u0, u1, t);
        w1 = blend(u1, u2, t);
        return blend(w0, w1, t);
    endfunction

    // quotient as t; false when negative or past one
    function automatic bit root_in_range(longint num, longint den, output longint unsigned t);
        longint unsigned q;
        t = 0;
        if (num != 0 && ((num < 0) != (den < 0))) return 1'b0;
        q = abs_val(num) / abs_val(den);
        if (q > T_UNIT) return 1'b0;
        t = q;
        return 1'b1;
    endfunction

    function automatic void widen(t_quad p, longint unsigned t, ref longint lo, ref longint hi);
        longint v, f, c;
        v = curve_at(p, t);
        f = round_down(v);
        c = -round_down(-v);
        if (f < lo) lo = f;
        if (c > hi) hi = c;
    endfunction

    // extent of one axis: end points plus in-range derivative roots
    function automatic void axis_extent(t_quad p, output longint lo, output longint hi);
        longint a, b, c, qa, qb, disc, scale, n1, n2;
        longint unsigned t, r;
        int s;
        a = p[3] - 3 * p[2] + 3 * p[1] - p[0];
        b = 3 * p[2] - 6 * p[1] + 3 * p[0];
        c = 3 * p[1] - 3 * p[0];
        qa = 3 * a;
        qb = 2 * b;
        lo = p[0] < p[3] ? p[0] : p[3];
        hi = p[0] > p[3] ? p[0] : p[3];
        if (qa == 0) begin
            // linear derivative
            if (qb != 0 && root_in_range(-c * longint'(T_UNIT), qb, t)) widen(p, t, lo, hi);
            return;
        end
        disc = qb * qb - 4 * qa * c;
        if (disc < 0) return;
        s = TF;
        while (s > 0 && ((longint'(disc) >> (62 - 2 * s)) != 0)) s--;
        r = int_sqrt(longint'(disc) << (2 * s));
        scale = longint'(64'd1 << (TF - s));
        n1 = (-qb * longint'(64'd1 << s) + longint'(r)) * scale;
        n2 = (-qb * longint'(64'd1 << s) - longint'(r)) * scale;
        if (root_in_range(n1, 2 * qa, t)) widen(p, t, lo, hi);
        if (root_in_range(n2, 2 * qa, t)) widen(p, t, lo, hi);
    endfunction

    function automatic t_box predict_box(t_curve cv);
        t_quad px, py;
        longint lo, hi;
        t_box bx;
        px = '{cv.start_x, cv.ctrl1_x, cv.ctrl2_x, cv.end_x};
        py = '{cv.start_y, cv.ctrl1_y, cv.ctrl2_y, cv.end_y};
        axis_extent(px, lo, hi);
        bx.box_min_x = t_coord'(lo);
        bx.box_max_x = t_coord'(hi);
        axis_extent(py, lo, hi);
        bx.box_min_y = t_coord'(lo);
        bx.box_max_y = t_coord'(hi);
        return bx;
    endfunction

    initial begin
        o_fail_cnt = 0;
        o_box_cnt = 0;
    end

    assign o_pending = box_queue.size();

    // compare each result with the oldest prediction, then log the new curve
    always @(posedge i_clk) begin
        t_box want;
        if (i_rst_n) begin
            if (i_done) begin
                o_box_cnt <= o_box_cnt + 1;
                if (box_queue.size() == 0) begin
                    $error("box with no curve outstanding: %h", i_box);
                    o_fail_cnt <= o_fail_cnt + 1;
                end else begin
                    want = box_queue.pop_front();
                    if (want != i_box) o_fail_cnt <= o_fail_cnt + 1;
                    if (want.box_min_x != i_box.box_min_x)
                        $error("box_min_x: expected %0d, got %0d", want.box_min_x, i_box.box_min_x);
                    if (want.box_max_x != i_box.box_max_x)
                        $error("box_max_x: expected %0d, got %0d", want.box_max_x, i_box.box_max_x);
                    if (want.box_min_y != i_box.box_min_y)
                        $error("box_min_y: expected %0d, got %0d", want.box_min_y, i_box.box_min_y);
                    if (want.box_max_y != i_box.box_max_y)
                        $error("box_max_y: expected %0d, got %0d", want.box_max_y, i_box.box_max_y);
                end
            end
            if (i_start && !i_busy) box_queue.push_back(predict_box(i_curve));
        end
    end

endmodule

>>> tb/cubic_bezier_bounding_box_top_tb.sv
// Testbench top: clock, reset, curve stimulus, watchdog and verdict.
// Depends on bbx_pkg, cubic_bezier_bounding_box_top and cubic_bezier_bounding_box_checker.
`timescale 1ns / 1ps

module cubic_bezier_bounding_box_top_tb;
    import bbx_pkg::*;

    localparam int N_RANDOM  = 2000;
    localparam int STALL_MAX = 20000;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_start = 1'b0;
    t_curve i_curve = '0;
    logic   o_busy;
    logic   o_done;
    t_box   o_box;

    int fail_cnt, pending, box_cnt;
    int stall_cycles = 0;
    int curves_sent = 0;

    always #5 i_clk = ~i_clk;

    cubic_bezier_bounding_box_top DUT (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(i_start),
        .i_curve(i_curve),
        .o_busy (o_busy),
        .o_done (o_done),
        .o_box  (o_box)
    );

    cubic_bezier_bounding_box_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (i_start),
        .i_busy    (o_busy),
        .i_curve   (i_curve),
        .i_done    (o_done),
        .i_box     (o_box),
        .o_fail_cnt(fail_cnt),
        .o_pending (pending),
        .o_box_cnt (box_cnt)
    );

    // watchdog: cycles with no transfer on either side
    always @(posedge i_clk) begin
        if ((i_start && !o_busy) || o_done || !i_rst_n) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_MAX) begin
            $display("watchdog: no transfer for %0d cycles", STALL_MAX);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // one curve transfer, with a random idle gap ahead of it
    task automatic send_curve(t_curve cv, int idle_pct);
        while ($urandom_range(99) < idle_pct) begin
            i_start <= 1'b0;
            @(posedge i_clk);
        end
        i_start <= 1'b1;
        i_curve <= cv;
        do @(posedge i_clk); while (o_busy);
        curves_sent++;
    endtask

    function automatic t_coord pick_coord(int mode, t_coord base);
        t_coord edges [6] = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1, 16'sh8001};
        case (mode)
            0: return t_coord'($urandom);
            1: return base + t_coord'($urandom_range(64) - 32);
            2: return edges[$urandom_range(5)];
            default: return t_coord'($urandom_range(2000) - 1000);
        endcase
    endfunction

    function automatic t_curve random_curve();
        t_curve cv;
        int mode;
        t_coord bx, by, dx, dy;
        mode = $urandom_range(3);
        bx = t_coord'($urandom);
        by = t_coord'($urandom);
        if ($urandom_range(9) == 0) begin
            // evenly spaced points: flat derivative or a linear one
            dx = t_coord'($urandom_range(20000) - 10000);
            dy = t_coord'($urandom_range(20000) - 10000);
            bx = t_coord'($urandom_range(20000) - 10000);
            by = t_coord'($urandom_range(20000) - 10000);
            cv = '{bx, by, bx + dx / 3, by + dy / 3, bx + 2 * dx / 3, by + 2 * dy / 3,
                   bx + dx, by + dy};
            return cv;
        end
        cv.start_x = pick_coord(mode, bx);
        cv.start_y = pick_coord(mode, by);
        cv.ctrl1_x = pick_coord(mode, bx);
        cv.ctrl1_y = pick_coord(mode, by);
        cv.ctrl2_x = pick_coord(mode, bx);
        cv.ctrl2_y = pick_coord(mode, by);
        cv.end_x   = pick_coord(mode, bx);
        cv.end_y   = pick_coord(mode, by);
        return cv;
    endfunction

    initial begin
        t_curve directed [$];
        int idle_pct [4] = '{0, 71, 0, 7};

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // extremes, straight lines, no-root, double-root and out-of-range roots
        directed.push_back('0);
        directed.push_back('{8{16'sh7fff}});
        directed.push_back('{8{16'sh8000}});
        directed.push_back('{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000,
                             16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
        directed.push_back('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                             16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff});
        directed.push_back('{16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff,
                             16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff});
        directed.push_back('{16'sd0, 16'sd0, 16'sd100, 16'sd100,
                             16'sd200, 16'sd200, 16'sd300, 16'sd300});
        directed.push_back('{16'sd0, 16'sd0, 16'sd100, 16'sd50,
                             16'sd100, 16'sd50, 16'sd0, 16'sd0});
        directed.push_back('{16'sd0, 16'sd0, 16'sd0, 16'sd0,
                             16'sd0, 16'sd0, 16'sd300, -16'sd300});
        directed.push_back('{16'sd0, 16'sd0, 16'sd30, 16'sd10,
                             16'sd60, 16'sd20, 16'sd90, 16'sd30});
        directed.push_back('{16'sd0, 16'sd0, 16'sd100, 16'sd100,
                             -16'sd100, -16'sd100, 16'sd0, 16'sd0});
        directed.push_back('{16'sd0, 16'sd0, 16'sd10, 16'sd1,
                             16'sd20, 16'sd2, 16'sd1000, 16'sd3});
        directed.push_back('{-16'sd500, 16'sd500, 16'sd1000, -16'sd1000,
                             -16'sd1000, 16'sd1000, 16'sd500, -16'sd500});
        directed.push_back('{16'sd1, -16'sd1, -16'sd1, 16'sd1,
                             16'sd1, -16'sd1, -16'sd1, 16'sd1});
        directed.push_back('{16'sd5, 16'sd5, 16'sd5, 16'sd5,
                             16'sd5, 16'sd5, 16'sd5, 16'sd5});
        directed.push_back('{16'sd0, 16'sd0, 16'sd3000, 16'sd7000,
                             16'sd9000, -16'sd7000, 16'sd9100, 16'sd0});
        directed.push_back('{16'sd0, 16'sd0, -16'sd20000, 16'sd0,
                             16'sd20000, 16'sd0, 16'sd1, 16'sd1});
        directed.push_back('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
                             16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000});
        foreach (directed[k]) send_curve(directed[k], 0);

        // random curves across the idle phases, with gap-free bursts in every phase
        for (int ph = 0; ph < 4; ph++) begin
            for (int k = 0; k < N_RANDOM / 4; k++)
                send_curve(random_curve(), (k % 100 < 20) ? 0 : idle_pct[ph]);
        end
        i_start <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (TOT_LAT + 10) @(posedge i_clk);

        $display("curves sent: %0d (directed %0d), boxes checked: %0d",
                 curves_sent, directed.size(), box_cnt);
        $display("sender idle phases 0/71/0/7 percent, extremes and degenerate curves included");
        if (fail_cnt == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
